>>> rtl/core/dfam_pkg.sv
// dfam_pkg: shared constants for the automaton runner / minimizer
// command codes, register indexes, scratch memory regions, default sizes
// no dependencies
`timescale 1ns / 1ps

package dfam_pkg;

    // default sizes
    localparam int MAX_STATES_DEF = 64;
    localparam int ALPHABET_DEF   = 256;

    // port field widths
    localparam int CMD_W   = 2;
    localparam int STATE_W = 6;
    localparam int SYM_W   = 8;
    localparam int CNT_W   = 7;
    localparam int CMP_W   = 9;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MARK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STEP = 2'd2;
    localparam logic [CMD_W-1:0] CMD_MIN  = 2'd3;

    // configuration register indexes
    localparam logic REG_STATE_COUNT = 1'b0;
    localparam logic REG_INIT_STATE  = 1'b1;

    // scratch memory regions: two label banks, then queue / block numbers
    localparam logic [1:0] RG_AUX = 2'd2;

endpackage

>>> rtl/core/dfa_runner_with_minimizer_unit.sv
// Automaton runner with minimizer: transition table, stepping, minimization
// Add, mark and step each read the table and answer with one word; minimize walks
// the table (reachability, then pairwise refinement rounds), then emits one word
// per state. A new command is taken only after the last one has put out its final word.
// Reset (aresetn low, synchronous) starts a pass that clears every table entry
// before the first word is taken.
// Depends on dfam_pkg and dfam_ram.
`timescale 1ns / 1ps

module dfa_runner_with_minimizer_unit #(
    parameter int MAX_STATES = dfam_pkg::MAX_STATES_DEF,
    parameter int ALPHABET   = dfam_pkg::ALPHABET_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [dfam_pkg::CNT_W-1:0]   cfg_wdata,
    // command words
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [dfam_pkg::CMD_W-1:0]   s_cmd,
    input  logic [dfam_pkg::STATE_W-1:0] s_from_state,
    input  logic [dfam_pkg::STATE_W-1:0] s_to_state,
    input  logic [dfam_pkg::SYM_W-1:0]   s_symbol,
    // result words
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_ok,
    output logic [dfam_pkg::STATE_W-1:0] m_state_index,
    output logic [dfam_pkg::STATE_W-1:0] m_value,
    output logic                         m_reachable,
    output logic                         m_last
);

    localparam int SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int YW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int CW = $clog2(MAX_STATES + 1);
    localparam int TW = SW + YW;
    localparam int RW = SW + 2;
    localparam int CP = dfam_pkg::CMP_W;
    localparam logic [YW-1:0] SYM_LAST = YW'(ALPHABET - 1);

    // sequencer states
    localparam logic [4:0] S_CLR     = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_CMD_RD  = 5'd2;
    localparam logic [4:0] S_CMD_EX  = 5'd3;
    localparam logic [4:0] S_M_INIT  = 5'd4;
    localparam logic [4:0] S_BFS_POP = 5'd5;
    localparam logic [4:0] S_BFS_S   = 5'd6;
    localparam logic [4:0] S_BFS_RD  = 5'd7;
    localparam logic [4:0] S_BFS_CHK = 5'd8;
    localparam logic [4:0] S_LAB     = 5'd9;
    localparam logic [4:0] S_R_START = 5'd10;
    localparam logic [4:0] S_R_S     = 5'd11;
    localparam logic [4:0] S_R_LS    = 5'd12;
    localparam logic [4:0] S_R_T     = 5'd13;
    localparam logic [4:0] S_R_LT    = 5'd14;
    localparam logic [4:0] S_C_RD    = 5'd15;
    localparam logic [4:0] S_C_TB    = 5'd16;
    localparam logic [4:0] S_C_LB    = 5'd17;
    localparam logic [4:0] S_O_START = 5'd18;
    localparam logic [4:0] S_O_RD    = 5'd19;
    localparam logic [4:0] S_O_LB    = 5'd20;
    localparam logic [4:0] S_O_BR    = 5'd21;
    localparam logic [4:0] S_O_EMIT  = 5'd22;

    logic [4:0]                   state_reg, state_next;
    logic [TW-1:0]                clr_reg, clr_next;
    logic [dfam_pkg::CNT_W-1:0]   cnt_cfg_reg, cnt_cfg_next;
    logic [dfam_pkg::STATE_W-1:0] init_reg, init_next;
    logic [SW-1:0]                cur_reg, cur_next;
    logic [dfam_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [dfam_pkg::STATE_W-1:0] from_reg, from_next;
    logic [dfam_pkg::STATE_W-1:0] to_reg, to_next;
    logic [dfam_pkg::SYM_W-1:0]   sym_reg, sym_next;
    logic [MAX_STATES-1:0]        acc_reg, acc_next;
    logic [MAX_STATES-1:0]        reach_reg, reach_next;
    logic [MAX_STATES-1:0]        rep_reg, rep_next;
    logic [CW-1:0]                head_reg, head_next;
    logic [CW-1:0]                tail_reg, tail_next;
    logic [SW-1:0]                bfs_s_reg, bfs_s_next;
    logic [YW-1:0]                symc_reg, symc_next;
    logic [SW-1:0]                s_reg, s_next;
    logic [SW-1:0]                t_reg, t_next;
    logic [SW-1:0]                labs_reg, labs_next;
    logic                         chg_reg, chg_next;
    logic                         sel_reg, sel_next;
    logic                         have_acc_reg, have_acc_next;
    logic [SW-1:0]                rep_acc_reg, rep_acc_next;
    logic                         have_non_reg, have_non_next;
    logic [SW-1:0]                rep_non_reg, rep_non_next;
    logic [SW-1:0]                rank_reg, rank_next;
    logic [SW-1:0]                bos_reg, bos_next;

    logic                         m_valid_reg, m_valid_next;
    logic                         m_ok_reg, m_ok_next;
    logic [dfam_pkg::STATE_W-1:0] m_si_reg, m_si_next;
    logic [dfam_pkg::STATE_W-1:0] m_val_reg, m_val_next;
    logic                         m_rch_reg, m_rch_next;
    logic                         m_last_reg, m_last_next;

    // memory ports
    logic          tbl_we;
    logic [TW-1:0] tbl_wa, tbl_ra, tbl_rb;
    logic [SW:0]   tbl_wd, tbl_qa, tbl_qb;
    logic          ram_we;
    logic [RW-1:0] ram_wa, ram_ra, ram_rb;
    logic [SW-1:0] ram_wd, ram_qa, ram_qb;

    logic [CW-1:0] cnt;
    logic [SW-1:0] from_idx, to_idx;
    logic [YW-1:0] sym_idx;
    logic          ea, eb, sym_ok, from_ok, to_ok, cur_ok, s_last, out_free;
    logic [1:0]    rg_old, rg_new;
    logic [SW-1:0] start_idx, lab_init;

    // effective state count, clamped to 1..MAX_STATES
    always_comb begin
        if (cnt_cfg_reg == '0) begin
            cnt = CW'(1);
        end else if (CP'(cnt_cfg_reg) > CP'(MAX_STATES)) begin
            cnt = CW'(MAX_STATES);
        end else begin
            cnt = CW'(cnt_cfg_reg);
        end
    end

    assign from_idx = SW'(from_reg);
    assign to_idx   = SW'(to_reg);
    assign sym_idx  = YW'(sym_reg);
    assign sym_ok   = CP'(sym_reg) < CP'(ALPHABET);
    assign from_ok  = CP'(from_reg) < CP'(cnt);
    assign to_ok    = CP'(to_reg) < CP'(cnt);
    assign cur_ok   = CP'(cur_reg) < CP'(cnt);
    assign s_last   = (CP'(s_reg) + CP'(1)) == CP'(cnt);
    assign out_free = !m_valid_reg || m_ready;
    assign rg_old   = {1'b0, sel_reg};
    assign rg_new   = {1'b0, !sel_reg};
    assign start_idx = (CP'(init_reg) < CP'(cnt)) ? SW'(init_reg) : '0;

    // usable transition: valid bit set and target in range
    assign ea = tbl_qa[SW] && (CP'(tbl_qa[SW-1:0]) < CP'(cnt));
    assign eb = tbl_qb[SW] && (CP'(tbl_qb[SW-1:0]) < CP'(cnt));

    // initial label: smallest reachable member with the same accepting mark
    always_comb begin
        lab_init = s_reg;
        if (reach_reg[s_reg]) begin
            if (acc_reg[s_reg]) begin
                if (have_acc_reg) lab_init = rep_acc_reg;
            end else begin
                if (have_non_reg) lab_init = rep_non_reg;
            end
        end
    end

    // table read addresses
    always_comb begin
        case (state_reg)
            S_CMD_RD, S_CMD_EX: begin
                tbl_ra = (cmd_reg == dfam_pkg::CMD_STEP) ? {cur_reg, sym_idx}
                                                         : {from_idx, sym_idx};
            end
            S_BFS_RD, S_BFS_CHK: tbl_ra = {bfs_s_reg, symc_reg};
            default:             tbl_ra = {t_reg, symc_reg};
        endcase
        tbl_rb = {s_reg, symc_reg};
    end

    // scratch read addresses
    always_comb begin
        case (state_reg)
            S_BFS_POP: ram_ra = {dfam_pkg::RG_AUX, head_reg[SW-1:0]};
            S_R_T:     ram_ra = {rg_old, t_reg};
            S_C_TB:    ram_ra = {rg_old, tbl_qa[SW-1:0]};
            S_O_LB:    ram_ra = {dfam_pkg::RG_AUX, ram_qa};
            default:   ram_ra = {rg_old, s_reg};
        endcase
        ram_rb = {rg_old, tbl_qb[SW-1:0]};
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        cnt_cfg_next  = cnt_cfg_reg;
        init_next     = init_reg;
        cur_next      = cur_reg;
        cmd_next      = cmd_reg;
        from_next     = from_reg;
        to_next       = to_reg;
        sym_next      = sym_reg;
        acc_next      = acc_reg;
        reach_next    = reach_reg;
        rep_next      = rep_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        bfs_s_next    = bfs_s_reg;
        symc_next     = symc_reg;
        s_next        = s_reg;
        t_next        = t_reg;
        labs_next     = labs_reg;
        chg_next      = chg_reg;
        sel_next      = sel_reg;
        have_acc_next = have_acc_reg;
        rep_acc_next  = rep_acc_reg;
        have_non_next = have_non_reg;
        rep_non_next  = rep_non_reg;
        rank_next     = rank_reg;
        bos_next      = bos_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_ok_next     = m_ok_reg;
        m_si_next     = m_si_reg;
        m_val_next    = m_val_reg;
        m_rch_next    = m_rch_reg;
        m_last_next   = m_last_reg;
        tbl_we        = 1'b0;
        tbl_wa        = {from_idx, sym_idx};
        tbl_wd        = {1'b1, to_idx};
        ram_we        = 1'b0;
        ram_wa        = {rg_new, s_reg};
        ram_wd        = s_reg;

        // configuration writes, to be made only while idle; the block itself does not enforce that
        if (cfg_we) begin
            if (cfg_index == dfam_pkg::REG_STATE_COUNT) begin
                cnt_cfg_next = cfg_wdata;
            end else begin
                init_next = dfam_pkg::STATE_W'(cfg_wdata);
                cur_next  = SW'(init_next);
            end
        end

        case (state_reg)
            // clear valid bits after reset
            S_CLR: begin
                tbl_we   = 1'b1;
                tbl_wa   = clr_reg;
                tbl_wd   = '0;
                clr_next = clr_reg + TW'(1);
                if (clr_reg == '1) state_next = S_IDLE;
            end

            S_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_cmd;
                    from_next  = s_from_state;
                    to_next    = s_to_state;
                    sym_next   = s_symbol;
                    state_next = (s_cmd == dfam_pkg::CMD_MIN) ? S_M_INIT : S_CMD_RD;
                end
            end

            S_CMD_RD: state_next = S_CMD_EX;

            // single-word commands
            S_CMD_EX: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_rch_next   = 1'b0;
                    m_last_next  = 1'b1;
                    m_val_next   = '0;
                    m_si_next    = from_reg;
                    state_next   = S_IDLE;
                    case (cmd_reg)
                        dfam_pkg::CMD_ADD: begin
                            m_ok_next = from_ok && to_ok && sym_ok && !ea;
                            tbl_we    = m_ok_next;
                        end
                        dfam_pkg::CMD_MARK: begin
                            m_ok_next = from_ok;
                            if (from_ok) acc_next[from_idx] = 1'b1;
                        end
                        default: begin
                            m_ok_next = cur_ok && sym_ok && ea;
                            m_si_next = dfam_pkg::STATE_W'(cur_reg);
                            if (m_ok_next) cur_next = tbl_qa[SW-1:0];
                            m_val_next = dfam_pkg::STATE_W'(cur_next);
                        end
                    endcase
                end
            end

            // reachability search from the start state
            S_M_INIT: begin
                reach_next            = '0;
                reach_next[start_idx] = 1'b1;
                ram_we                = 1'b1;
                ram_wa                = {dfam_pkg::RG_AUX, {SW{1'b0}}};
                ram_wd                = start_idx;
                head_next             = '0;
                tail_next             = CW'(1);
                sel_next              = 1'b0;
                state_next            = S_BFS_POP;
            end

            S_BFS_POP: begin
                if (head_reg == tail_reg) begin
                    s_next        = '0;
                    have_acc_next = 1'b0;
                    have_non_next = 1'b0;
                    state_next    = S_LAB;
                end else begin
                    head_next  = head_reg + CW'(1);
                    state_next = S_BFS_S;
                end
            end

            S_BFS_S: begin
                bfs_s_next = ram_qa;
                symc_next  = '0;
                state_next = S_BFS_RD;
            end

            S_BFS_RD: state_next = S_BFS_CHK;

            S_BFS_CHK: begin
                if (ea && !reach_reg[tbl_qa[SW-1:0]]) begin
                    reach_next[tbl_qa[SW-1:0]] = 1'b1;
                    ram_we    = 1'b1;
                    ram_wa    = {dfam_pkg::RG_AUX, tail_reg[SW-1:0]};
                    ram_wd    = tbl_qa[SW-1:0];
                    tail_next = tail_reg + CW'(1);
                end
                symc_next  = symc_reg + YW'(1);
                state_next = (symc_reg == SYM_LAST) ? S_BFS_POP : S_BFS_RD;
            end

            // accepting / non-accepting split into bank 0
            S_LAB: begin
                ram_we = 1'b1;
                ram_wa = {rg_old, s_reg};
                ram_wd = lab_init;
                if (reach_reg[s_reg]) begin
                    if (acc_reg[s_reg] && !have_acc_reg) begin
                        have_acc_next = 1'b1;
                        rep_acc_next  = s_reg;
                    end
                    if (!acc_reg[s_reg] && !have_non_reg) begin
                        have_non_next = 1'b1;
                        rep_non_next  = s_reg;
                    end
                end
                s_next     = s_reg + SW'(1);
                state_next = s_last ? S_R_START : S_LAB;
            end

            // one refinement round
            S_R_START: begin
                s_next     = '0;
                chg_next   = 1'b0;
                rep_next   = '0;
                state_next = S_R_S;
            end

            S_R_S: begin
                if (!reach_reg[s_reg]) begin
                    ram_we = 1'b1;
                    if (s_last) begin
                        sel_next   = !sel_reg;
                        state_next = chg_reg ? S_R_START : S_O_START;
                    end else begin
                        s_next = s_reg + SW'(1);
                    end
                end else begin
                    state_next = S_R_LS;
                end
            end

            S_R_LS: begin
                labs_next  = ram_qa;
                t_next     = '0;
                state_next = S_R_T;
            end

            S_R_T: begin
                if (t_reg == s_reg) begin
                    // no earlier partner: s heads its own block
                    ram_we           = 1'b1;
                    rep_next[s_reg]  = 1'b1;
                    chg_next         = chg_reg || (labs_reg != s_reg);
                    if (s_last) begin
                        sel_next   = !sel_reg;
                        state_next = chg_next ? S_R_START : S_O_START;
                    end else begin
                        s_next     = s_reg + SW'(1);
                        state_next = S_R_S;
                    end
                end else if (reach_reg[t_reg] && rep_reg[t_reg]) begin
                    state_next = S_R_LT;
                end else begin
                    t_next = t_reg + SW'(1);
                end
            end

            S_R_LT: begin
                if (ram_qa == labs_reg) begin
                    symc_next  = '0;
                    state_next = S_C_RD;
                end else begin
                    t_next     = t_reg + SW'(1);
                    state_next = S_R_T;
                end
            end

            // symbol-by-symbol comparison of t and s
            S_C_RD: state_next = S_C_TB;

            S_C_TB, S_C_LB: begin
                if ((state_reg == S_C_TB && ea != eb) ||
                    (state_reg == S_C_LB && ram_qa != ram_qb)) begin
                    t_next     = t_reg + SW'(1);
                    state_next = S_R_T;
                end else if (state_reg == S_C_TB && ea) begin
                    state_next = S_C_LB;
                end else if (symc_reg != SYM_LAST) begin
                    symc_next  = symc_reg + YW'(1);
                    state_next = S_C_RD;
                end else begin
                    // all symbols agree: s joins t
                    ram_we   = 1'b1;
                    ram_wd   = t_reg;
                    chg_next = chg_reg || (labs_reg != t_reg);
                    if (s_last) begin
                        sel_next   = !sel_reg;
                        state_next = chg_next ? S_R_START : S_O_START;
                    end else begin
                        s_next     = s_reg + SW'(1);
                        state_next = S_R_S;
                    end
                end
            end

            // block numbering and result words
            S_O_START: begin
                s_next     = '0;
                rank_next  = '0;
                state_next = S_O_RD;
            end

            S_O_RD: state_next = S_O_LB;

            S_O_LB: begin
                if (!reach_reg[s_reg]) begin
                    bos_next   = '0;
                    state_next = S_O_EMIT;
                end else if (ram_qa == s_reg) begin
                    bos_next   = rank_reg;
                    ram_we     = 1'b1;
                    ram_wa     = {dfam_pkg::RG_AUX, s_reg};
                    ram_wd     = rank_reg;
                    rank_next  = rank_reg + SW'(1);
                    state_next = S_O_EMIT;
                end else begin
                    state_next = S_O_BR;
                end
            end

            S_O_BR: begin
                bos_next   = ram_qa;
                state_next = S_O_EMIT;
            end

            S_O_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = 1'b1;
                    m_si_next    = dfam_pkg::STATE_W'(s_reg);
                    m_val_next   = dfam_pkg::STATE_W'(bos_reg);
                    m_rch_next   = reach_reg[s_reg];
                    m_last_next  = s_last;
                    s_next       = s_reg + SW'(1);
                    state_next   = s_last ? S_IDLE : S_O_RD;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            cnt_cfg_reg <= dfam_pkg::CNT_W'(64);
            init_reg    <= '0;
            cur_reg     <= '0;
            acc_reg     <= '0;
            reach_reg   <= '0;
            rep_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            cnt_cfg_reg <= cnt_cfg_next;
            init_reg    <= init_next;
            cur_reg     <= cur_next;
            acc_reg     <= acc_next;
            reach_reg   <= reach_next;
            rep_reg     <= rep_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        from_reg     <= from_next;
        to_reg       <= to_next;
        sym_reg      <= sym_next;
        head_reg     <= head_next;
        tail_reg     <= tail_next;
        bfs_s_reg    <= bfs_s_next;
        symc_reg     <= symc_next;
        s_reg        <= s_next;
        t_reg        <= t_next;
        labs_reg     <= labs_next;
        chg_reg      <= chg_next;
        sel_reg      <= sel_next;
        have_acc_reg <= have_acc_next;
        rep_acc_reg  <= rep_acc_next;
        have_non_reg <= have_non_next;
        rep_non_reg  <= rep_non_next;
        rank_reg     <= rank_next;
        bos_reg      <= bos_next;
        m_ok_reg     <= m_ok_next;
        m_si_reg     <= m_si_next;
        m_val_reg    <= m_val_next;
        m_rch_reg    <= m_rch_next;
        m_last_reg   <= m_last_next;
    end

    // transition table: valid bit and target per entry
    dfam_ram #(
        .AW (TW),
        .DW (SW + 1)
    ) u_table (
        .aclk    (aclk),
        .we      (tbl_we),
        .waddr   (tbl_wa),
        .wdata   (tbl_wd),
        .raddr_a (tbl_ra),
        .raddr_b (tbl_rb),
        .rdata_a (tbl_qa),
        .rdata_b (tbl_qb)
    );

    // scratch: two label banks, work queue / block numbers
    dfam_ram #(
        .AW (RW),
        .DW (SW)
    ) u_scratch (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_wa),
        .wdata   (ram_wd),
        .raddr_a (ram_ra),
        .raddr_b (ram_rb),
        .rdata_a (ram_qa),
        .rdata_b (ram_qb)
    );

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_ok          = m_ok_reg;
    assign m_state_index = m_si_reg;
    assign m_value       = m_val_reg;
    assign m_reachable   = m_rch_reg;
    assign m_last        = m_last_reg;

endmodule

>>> rtl/core/dfam_ram.sv
// dfam_ram: simple memory, one write port and two registered read ports
// used for the transition table and for the minimizer scratch storage
// no dependencies
`timescale 1ns / 1ps

module dfam_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [2**AW];

    // write port and registered reads
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> rtl/core/dfam_chk.sv
// dfam_chk: port-level checks for the automaton runner / minimizer
// bound to dfa_runner_with_minimizer_unit; depends on dfam_pkg
`timescale 1ns / 1ps

module dfam_chk (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_ok,
    input logic [dfam_pkg::STATE_W-1:0] m_state_index,
    input logic [dfam_pkg::STATE_W-1:0] m_value,
    input logic                         m_reachable,
    input logic                         m_last
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_state_index) && $stable(m_value))
        else $error("result word changed while stalled");

    // a refused command always gives a single word
    a_fail_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> m_last)
        else $error("failed result not marked last");

    // reachable states only come from minimize, which always succeeds
    a_reach_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reachable |-> m_ok)
        else $error("reachable flag on a failed result");

    // one command at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("command taken while busy");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind dfa_runner_with_minimizer_unit dfam_chk u_dfam_chk (.*);

>>> tb/dfam_checker.sv
// dfam_checker: watches the command, result and register ports of the automaton unit,
// keeps its own copy of the table and marks, predicts each result word and compares
// depends on dfam_pkg
`timescale 1ns / 1ps

module dfam_checker
    import dfam_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [CNT_W-1:0]   cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [CMD_W-1:0]   s_cmd,
    input  logic [STATE_W-1:0] s_from_state,
    input  logic [STATE_W-1:0] s_to_state,
    input  logic [SYM_W-1:0]   s_symbol,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_ok,
    input  logic [STATE_W-1:0] m_state_index,
    input  logic [STATE_W-1:0] m_value,
    input  logic               m_reachable,
    input  logic               m_last,
    output int                 fail_count,
    output int                 pending
);

    localparam int NSTATES = MAX_STATES_DEF;
    localparam int NSYMS   = ALPHABET_DEF;

    typedef struct packed {
        logic               ok;
        logic [STATE_W-1:0] idx;
        logic [STATE_W-1:0] val;
        logic               rch;
        logic               last;
    } result_word_t;

    result_word_t result_q[$];
    int err_total;

    // shadow automaton
    bit           edge_set[NSTATES*NSYMS];
    int           edge_dst[NSTATES*NSYMS];
    bit           acc_mark[NSTATES];
    bit           reached[NSTATES];
    int           block_num[NSTATES];
    int           lab_cur[NSTATES];
    int           lab_nxt[NSTATES];
    int           bfs_q[NSTATES];
    int unsigned  count_reg;
    int unsigned  start_reg;
    int unsigned  cur_state;

    function automatic int live_count();
        if (count_reg < 1) return 1;
        if (count_reg > NSTATES) return NSTATES;
        return count_reg;
    endfunction

    // -1 when there is no usable transition
    function automatic int next_of(int s, int sym, int c);
        int t;
        if (s >= c || sym >= NSYMS) return -1;
        if (!edge_set[s*NSYMS+sym]) return -1;
        t = edge_dst[s*NSYMS+sym];
        if (t >= c) return -1;
        return t;
    endfunction

    function automatic bit same_moves(int a, int b, int c);
        int ta, tb;
        for (int sym = 0; sym < NSYMS; sym++) begin
            ta = next_of(a, sym, c);
            tb = next_of(b, sym, c);
            if ((ta < 0) != (tb < 0)) return 0;
            if (ta >= 0 && lab_cur[ta] != lab_cur[tb]) return 0;
        end
        return 1;
    endfunction

    task automatic calc_blocks(int c);
        int head, tail, s, tg, rank;
        bit changed;
        head = 0;
        tail = 0;
        // reachability from the start state
        for (int i = 0; i < NSTATES; i++) reached[i] = 0;
        s = (start_reg < c) ? start_reg : 0;
        reached[s] = 1;
        bfs_q[tail++] = s;
        while (head < tail) begin
            s = bfs_q[head++];
            for (int sym = 0; sym < NSYMS; sym++) begin
                tg = next_of(s, sym, c);
                if (tg >= 0 && !reached[tg] && tail < NSTATES) begin
                    reached[tg] = 1;
                    bfs_q[tail++] = tg;
                end
            end
        end
        // accepting split, labeled by smallest member
        for (int i = 0; i < c; i++) begin
            lab_cur[i] = i;
            if (reached[i]) begin
                for (int j = 0; j < i; j++) begin
                    if (reached[j] && acc_mark[j] == acc_mark[i]) begin
                        lab_cur[i] = j;
                        break;
                    end
                end
            end
        end
        // refine until stable
        do begin
            changed = 0;
            for (int i = 0; i < c; i++) begin
                lab_nxt[i] = i;
                if (reached[i]) begin
                    for (int j = 0; j < i; j++) begin
                        if (reached[j] && lab_nxt[j] == j && lab_cur[j] == lab_cur[i]
                                && same_moves(j, i, c)) begin
                            lab_nxt[i] = j;
                            break;
                        end
                    end
                    if (lab_nxt[i] != lab_cur[i]) changed = 1;
                end
            end
            for (int i = 0; i < NSTATES; i++) lab_cur[i] = lab_nxt[i];
        end while (changed);
        // number blocks in order of smallest member
        rank = 0;
        for (int i = 0; i < c; i++) begin
            if (!reached[i]) block_num[i] = 0;
            else if (lab_cur[i] == i) block_num[i] = rank++;
            else block_num[i] = block_num[lab_cur[i]];
        end
    endtask

    task automatic push_result(bit ok, int idx, int val, bit rch, bit last);
        result_word_t w;
        w.ok   = ok;
        w.idx  = idx[STATE_W-1:0];
        w.val  = val[STATE_W-1:0];
        w.rch  = rch;
        w.last = last;
        result_q = {result_q, w};
    endtask

    task automatic predict_word();
        int c, f, t, sym, tg, prev_cur;
        bit ok;
        c = live_count();
        f = s_from_state;
        t = s_to_state;
        sym = s_symbol;
        case (s_cmd)
            CMD_ADD: begin
                ok = 0;
                if (f < c && t < c && next_of(f, sym, c) < 0) begin
                    edge_set[f*NSYMS+sym] = 1;
                    edge_dst[f*NSYMS+sym] = t;
                    ok = 1;
                end
                push_result(ok, f, 0, 0, 1);
            end
            CMD_MARK: begin
                ok = (f < c);
                if (ok) acc_mark[f] = 1;
                push_result(ok, f, 0, 0, 1);
            end
            CMD_STEP: begin
                prev_cur = cur_state;
                tg = next_of(cur_state, sym, c);
                if (tg >= 0) cur_state = tg;
                push_result(tg >= 0, prev_cur, cur_state, 0, 1);
            end
            default: begin
                calc_blocks(c);
                for (int i = 0; i < c; i++)
                    push_result(1, i, block_num[i], reached[i], i + 1 == c);
            end
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s at %0t: got %0d, want %0d", what, $time, got, want);
        err_total++;
    endtask

    always @(posedge aclk) begin
        result_word_t want;
        if (!aresetn) begin
            for (int i = 0; i < NSTATES*NSYMS; i++) edge_set[i] = 0;
            for (int i = 0; i < NSTATES; i++) begin
                acc_mark[i] = 0;
                reached[i] = 0;
                block_num[i] = 0;
            end
            count_reg = NSTATES;
            start_reg = 0;
            cur_state = 0;
            result_q.delete();
            err_total = 0;
        end else begin
            // register writes
            if (cfg_we) begin
                if (cfg_index == REG_STATE_COUNT) begin
                    count_reg = cfg_wdata;
                end else begin
                    start_reg = cfg_wdata[STATE_W-1:0];
                    cur_state = start_reg;
                end
            end
            // result words against the oldest prediction
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected word, state_index", m_state_index, -1);
                end else begin
                    want = result_q.pop_front();
                    if (m_ok !== want.ok) report_mismatch("ok", m_ok, want.ok);
                    if (m_state_index !== want.idx)
                        report_mismatch("state_index", m_state_index, want.idx);
                    if (m_value !== want.val) report_mismatch("value", m_value, want.val);
                    if (m_reachable !== want.rch)
                        report_mismatch("reachable", m_reachable, want.rch);
                    if (m_last !== want.last) report_mismatch("last", m_last, want.last);
                end
            end
            // command words
            if (s_valid && s_ready) predict_word();
        end
        fail_count <= err_total;
        pending <= result_q.size();
    end

endmodule

>>> tb/dfa_runner_with_minimizer_unit_test.sv
// dfa_runner_with_minimizer_unit_test: drives command words and register writes into
// the automaton unit under varying idle and stall patterns; dfam_checker judges results
// depends on dfam_pkg, dfam_checker and the unit's RTL
`timescale 1ns / 1ps

module dfa_runner_with_minimizer_unit_test;
    import dfam_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000000;
    localparam int HOLD_CYCLES    = 400;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic               cfg_index;
    logic [CNT_W-1:0]   cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [CMD_W-1:0]   s_cmd;
    logic [STATE_W-1:0] s_from_state;
    logic [STATE_W-1:0] s_to_state;
    logic [SYM_W-1:0]   s_symbol;
    logic               m_valid;
    logic               m_ready;
    logic               m_ok;
    logic [STATE_W-1:0] m_state_index;
    logic [STATE_W-1:0] m_value;
    logic               m_reachable;
    logic               m_last;
    logic               hold_go;
    int                 fail_count;
    int                 pending;
    int                 src_idle_pct;
    int                 sink_stall_pct;
    int                 hold_left;
    int                 quiet_cycles;

    dfa_runner_with_minimizer_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_from_state  (s_from_state),
        .s_to_state    (s_to_state),
        .s_symbol      (s_symbol),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ok          (m_ok),
        .m_state_index (m_state_index),
        .m_value       (m_value),
        .m_reachable   (m_reachable),
        .m_last        (m_last)
    );

    dfam_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_from_state  (s_from_state),
        .s_to_state    (s_to_state),
        .s_symbol      (s_symbol),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ok          (m_ok),
        .m_state_index (m_state_index),
        .m_value       (m_value),
        .m_reachable   (m_reachable),
        .m_last        (m_last),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // clock
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // result side: random stalls plus a long hold-off when hold_go is raised
    always @(posedge aclk) begin
        if (hold_go) hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // watchdog on cycles without any handshake or register write
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("dfa_runner_with_minimizer_unit verification failed");
            $finish;
        end
    end

    // one command word; valid stays up into the next word when there is no gap
    task automatic put_word(logic [CMD_W-1:0] cmd, int from, int to, int sym);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_from_state <= from[STATE_W-1:0];
        s_to_state   <= to[STATE_W-1:0];
        s_symbol     <= sym[SYM_W-1:0];
        do @(posedge aclk); while (!s_ready);
    endtask

    // wait for all results, then for the tail of a minimize
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CNT_W-1:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // mostly small-alphabet adds and steps so the table has structure
    task automatic random_word(int cnt);
        int r, sym;
        r = $urandom_range(99);
        sym = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(3);
        if (r < 40)
            put_word(CMD_ADD, $urandom_range(cnt - 1), $urandom_range(cnt - 1), sym);
        else if (r < 55)
            put_word(CMD_MARK, $urandom_range(cnt - 1), $urandom_range(63), sym);
        else if (r < 85)
            put_word(CMD_STEP, $urandom_range(63), $urandom_range(63), sym);
        else
            put_word(CMD_W'($urandom_range(2)), $urandom_range(63), $urandom_range(63),
                     $urandom_range(255));
    endtask

    initial begin
        int src_tab[4];
        int sink_tab[4];
        int cnt;
        src_tab  = '{0, 48, 0, 11};
        sink_tab = '{0, 0, 48, 11};
        aresetn        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= REG_STATE_COUNT;
        cfg_wdata      <= '0;
        s_valid        <= 1'b0;
        s_cmd          <= CMD_ADD;
        s_from_state   <= '0;
        s_to_state     <= '0;
        s_symbol       <= '0;
        m_ready        <= 1'b0;
        hold_go        <= 1'b0;
        hold_left      = 0;
        quiet_cycles   = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // full-size table: field extremes, duplicate add, stepping
        put_word(CMD_ADD, 0, 1, 0);
        put_word(CMD_ADD, 0, 2, 0);
        put_word(CMD_ADD, 63, 63, 255);
        put_word(CMD_ADD, 1, 63, 255);
        put_word(CMD_ADD, 0, 63, 5);
        put_word(CMD_MARK, 63, 0, 0);
        put_word(CMD_STEP, 0, 0, 0);
        put_word(CMD_STEP, 0, 0, 255);
        put_word(CMD_STEP, 0, 0, 255);
        put_word(CMD_STEP, 0, 0, 7);

        // count of zero clamps to one state
        settle();
        write_reg(REG_STATE_COUNT, 0);
        write_reg(REG_INIT_STATE, 0);
        put_word(CMD_ADD, 0, 0, 3);
        put_word(CMD_STEP, 0, 0, 3);
        put_word(CMD_MIN, 0, 0, 0);

        // count above the maximum clamps; start at the top state
        settle();
        write_reg(REG_STATE_COUNT, 127);
        write_reg(REG_INIT_STATE, 63);
        put_word(CMD_STEP, 0, 0, 255);
        put_word(CMD_MARK, 0, 0, 0);

        // small count: stale edge, refused operands, start state out of range
        settle();
        write_reg(REG_STATE_COUNT, 4);
        write_reg(REG_INIT_STATE, 10);
        put_word(CMD_STEP, 0, 0, 0);
        put_word(CMD_ADD, 0, 2, 5);
        put_word(CMD_ADD, 5, 1, 1);
        put_word(CMD_ADD, 1, 9, 1);
        put_word(CMD_MARK, 10, 0, 0);
        put_word(CMD_ADD, 2, 3, 0);
        put_word(CMD_MIN, 0, 0, 0);

        // random phases over the idle patterns
        for (int ph = 0; ph < 4; ph++) begin
            settle();
            src_idle_pct   = src_tab[ph];
            sink_stall_pct = sink_tab[ph];
            cnt = $urandom_range(6, 2);
            write_reg(REG_STATE_COUNT, cnt);
            write_reg(REG_INIT_STATE, $urandom_range(7));
            for (int i = 0; i < 22; i++) random_word(cnt);
            put_word(CMD_MIN, $urandom_range(63), $urandom_range(63), $urandom_range(255));
        end

        // long hold-off on results while commands keep coming
        settle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_go <= 1'b1;
        @(posedge aclk);
        hold_go <= 1'b0;
        for (int i = 0; i < 20; i++) random_word(cnt);
        put_word(CMD_MIN, 0, 0, 0);

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("dfa_runner_with_minimizer_unit verification clean");
        end else begin
            $display("dfa_runner_with_minimizer_unit verification failed");
        end
        $finish;
    end

endmodule
